@@ rtl/core/rhc_pkg.sv @@
package rhc_pkg;

   // fixed channel width of the pixel fields
   localparam int CHAN_W = 8;

   // quotient bits out of each divider lane (hue and saturation are 8 bits)
   localparam int QUO_W = 8;

   // sector sum S*C+D stays below 6*C <= 1530
   localparam int SUM_W = 11;

   // divisor width: 6*C for hue, M for saturation
   localparam int DEN_W = 11;

   // dividend width: 255*(S*C+D) < 2^19
   localparam int NUM_W = 19;

   // default depth of the queue between classification and division
   localparam int QUEUE_DEPTH_DEF = 4;

   // one classified pixel, as it waits for the divider
   typedef struct packed {
      logic              grey;        // chroma is zero, hue forced to zero
      logic              black;       // value is zero, saturation forced to zero
      logic [SUM_W-1:0]  sector_sum;  // S*C + D, never negative
      logic [CHAN_W-1:0] chroma;
      logic [CHAN_W-1:0] value;
   } rhc_item_type;

endpackage

@@ rtl/core/rhc_front.sv @@
module rhc_front
   import rhc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CHAN_W-1:0]   red,
   input  logic [CHAN_W-1:0]   green,
   input  logic [CHAN_W-1:0]   blue,
   output logic                out_valid,
   input  logic                out_ready,
   output rhc_item_type        out_item
);

   logic              valid_ff, valid_in;
   rhc_item_type      item_ff, item_in;
   logic              take, give;

   logic [CHAN_W-1:0] hi, lo, chroma;
   logic [11:0]       sc_term, diff_term, sum_full;
   logic [11:0]       c12;

   assign give     = valid_ff & out_ready;
   assign in_ready = ~valid_ff | out_ready;
   assign take     = in_valid & in_ready;

   // largest and smallest channel
   always_comb begin
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      chroma = hi - lo;
   end

   // sector pick, ties to red then green; red sector wraps by adding six chromas
   always_comb begin
      c12 = {4'b0, chroma};
      if (hi == red) begin
         diff_term = {4'b0, green} - {4'b0, blue};
         sc_term   = (green < blue) ? ((c12 << 2) + (c12 << 1)) : 12'd0;
      end else if (hi == green) begin
         diff_term = {4'b0, blue} - {4'b0, red};
         sc_term   = c12 << 1;
      end else begin
         diff_term = {4'b0, red} - {4'b0, green};
         sc_term   = c12 << 2;
      end
      sum_full = sc_term + diff_term;
   end

   always_comb begin
      item_in.grey       = (chroma == '0);
      item_in.black      = (hi == '0);
      item_in.sector_sum = sum_full[SUM_W-1:0];
      item_in.chroma     = chroma;
      item_in.value      = hi;
   end

   // holding register
   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b1;
      else if (give) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/core/rhc_queue.sv @@
module rhc_queue
   import rhc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  rhc_item_type  in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output rhc_item_type  out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rhc_item_type     store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign out_item  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push & ~pop) count_in = count_ff + 1'b1;
      else if (pop & ~push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_item;
      end
   end

   // queue bookkeeping checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

@@ rtl/core/rhc_back.sv @@
module rhc_back
   import rhc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rhc_item_type        in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [CHAN_W-1:0]   hue,
   output logic [CHAN_W-1:0]   saturation,
   output logic [CHAN_W-1:0]   value
);

   // one restoring step per quotient bit, plus the dividend setup stage
   localparam int STAGES = QUO_W + 1;

   typedef struct packed {
      logic [NUM_W-1:0]  rem_h;
      logic [NUM_W-1:0]  rem_s;
      logic [DEN_W-1:0]  den_h;
      logic [DEN_W-1:0]  den_s;
      logic [QUO_W-1:0]  quo_h;
      logic [QUO_W-1:0]  quo_s;
      logic              grey;
      logic              black;
      logic [CHAN_W-1:0] value;
   } div_stage_type;

   div_stage_type st_ff [STAGES];
   div_stage_type st_in [STAGES];
   logic          vld_ff [STAGES];
   logic          advance;

   // whole pipe moves unless the result register is held
   assign advance  = ~vld_ff[STAGES-1] | out_ready;
   assign in_ready = advance;

   // setup: dividends 255*x, divisors 6*C and M
   always_comb begin
      logic [NUM_W-1:0] t_w, c_w;
      logic [DEN_W-1:0] c_d;
      t_w = {{(NUM_W - SUM_W){1'b0}}, in_item.sector_sum};
      c_w = {{(NUM_W - CHAN_W){1'b0}}, in_item.chroma};
      c_d = {{(DEN_W - CHAN_W){1'b0}}, in_item.chroma};
      st_in[0].rem_h = (t_w << 8) - t_w;
      st_in[0].rem_s = (c_w << 8) - c_w;
      st_in[0].den_h = (c_d << 2) + (c_d << 1);
      st_in[0].den_s = {{(DEN_W - CHAN_W){1'b0}}, in_item.value};
      st_in[0].quo_h = '0;
      st_in[0].quo_s = '0;
      st_in[0].grey  = in_item.grey;
      st_in[0].black = in_item.black;
      st_in[0].value = in_item.value;
   end

   // restoring steps, most significant quotient bit first
   for (genvar j = 1; j < STAGES; j++) begin : g_step
      localparam int K = QUO_W - j;
      always_comb begin
         logic [NUM_W-1:0] trial_h, trial_s;
         trial_h  = {{(NUM_W - DEN_W){1'b0}}, st_ff[j-1].den_h} << K;
         trial_s  = {{(NUM_W - DEN_W){1'b0}}, st_ff[j-1].den_s} << K;
         st_in[j] = st_ff[j-1];
         if (st_ff[j-1].rem_h >= trial_h) begin
            st_in[j].rem_h = st_ff[j-1].rem_h - trial_h;
            st_in[j].quo_h = st_ff[j-1].quo_h | (QUO_W'(1) << K);
         end
         if (st_ff[j-1].rem_s >= trial_s) begin
            st_in[j].rem_s = st_ff[j-1].rem_s - trial_s;
            st_in[j].quo_s = st_ff[j-1].quo_s | (QUO_W'(1) << K);
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < STAGES; i++) st_ff[i] <= st_in[i];
      end
   end

   // grey and black pixels override the quotients
   assign out_valid  = vld_ff[STAGES-1];
   assign hue        = st_ff[STAGES-1].grey  ? '0 : st_ff[STAGES-1].quo_h;
   assign saturation = st_ff[STAGES-1].black ? '0 : st_ff[STAGES-1].quo_s;
   assign value      = st_ff[STAGES-1].value;

   // result held while stalled
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && !out_ready) |=> vld_ff[STAGES-1])
      else $error("result dropped during stall");

   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && !out_ready) |=> $stable(st_ff[STAGES-1].quo_h))
      else $error("hue changed during stall");

   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && st_ff[STAGES-1].black) |-> st_ff[STAGES-1].grey)
      else $error("black pixel with nonzero chroma");

endmodule

@@ rtl/core/rgb_to_hsv_converter_core.sv @@
// Path from the input transfer to the result: classification register, queue,
// dividend setup, eight restoring divide stages; one quotient bit per stage.
// Throughput: one pixel per cycle while the result side does not stall.
// A stalled result side backs up the divide pipe; the queue keeps the front accepting until full.
// Reset is synchronous, active high, and empties the front, queue and pipe.
module rgb_to_hsv_converter_core
   import rhc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue[7:0], saturation[15:8], value[23:16]
);

   logic         fq_valid, fq_ready;
   rhc_item_type fq_item;
   logic         qb_valid, qb_ready;
   rhc_item_type qb_item;
   logic [CHAN_W-1:0] hue, saturation, value;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   rhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   rhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_item    (qb_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .value      (value)
   );

   assign rsp_tdata = {value, saturation, hue};

endmodule

@@ verif/tb_rgb_to_hsv_converter_core.sv @@
module tb_rgb_to_hsv_converter_core;
   import rhc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 450;
   localparam int CALM_PIXELS   = 60;    // tail of the run with no idling
   localparam int HOLD_AT       = 120;   // random pixel that triggers the long result stall
   localparam int DRAIN_AT      = 260;   // random pixel before which the sender drains the block
   localparam int LONG_HOLD     = 400;   // cycles the result side holds off
   localparam int SETTLE_CYCLES = 30;    // wait after the drain for stray results
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;

   typedef logic [CHAN_W-1:0] chan_type;

   // packed so that the struct maps onto tdata, last field lowest
   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } rgb_type;

   typedef struct packed {
      chan_type value;
      chan_type saturation;
      chan_type hue;
   } hsv_type;

   typedef struct packed {
      rgb_type pixel;
      logic    known;   // expected result typed in below
      hsv_type hsv;
   } pixel_case_type;

   // pixel fields are {blue, green, red}, results {value, saturation, hue}
   localparam int NUM_CASES = 24;
   localparam pixel_case_type PIXEL_CASES [0:NUM_CASES-1] = '{
      '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},  // black
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0  }},  // white
      '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd0,   8'd0  }},  // grey
      '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{8'd1,   8'd0,   8'd0  }},  // darkest grey
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd0  }},  // pure red
      '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{8'd255, 8'd255, 8'd85 }},  // pure green
      '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{8'd255, 8'd255, 8'd170}},  // pure blue
      '{'{8'd1,   8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd254}},  // red, wraps to top
      '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd212}},  // red ties blue
      '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd42 }},  // red ties green
      '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{8'd255, 8'd255, 8'd127}},  // green ties blue
      '{'{8'd0,   8'd0,   8'd1  }, 1'b1, '{8'd1,   8'd255, 8'd0  }},  // dimmest red
      '{'{8'd50,  8'd100, 8'd200}, 1'b0, '0},
      '{'{8'd100, 8'd200, 8'd50 }, 1'b0, '0},
      '{'{8'd200, 8'd50,  8'd100}, 1'b0, '0},
      '{'{8'd30,  8'd20,  8'd10 }, 1'b0, '0},
      '{'{8'd253, 8'd254, 8'd255}, 1'b0, '0},
      '{'{8'd129, 8'd127, 8'd128}, 1'b0, '0},
      '{'{8'd0,   8'd255, 8'd254}, 1'b0, '0},
      '{'{8'd255, 8'd1,   8'd0  }, 1'b0, '0},
      '{'{8'd0,   8'd85,  8'd170}, 1'b0, '0},
      '{'{8'd170, 8'd0,   8'd85 }, 1'b0, '0},
      '{'{8'd250, 8'd3,   8'd7  }, 1'b0, '0},
      '{'{8'd128, 8'd16,  8'd240}, 1'b0, '0}
   };

   logic     clock      = 1'b0;
   logic     reset      = 1'b1;
   logic     req_tvalid = 1'b0;
   logic     req_tready;
   rgb_type  req_tdata  = '0;
   logic     rsp_tvalid;
   logic     rsp_tready = 1'b0;
   hsv_type  rsp_tdata;

   hsv_type  offer_hsv = '0;     // expectation that travels with req_tdata
   hsv_type  hsv_due[$];         // expected results, oldest first
   int       fault_count = 0;
   int       cycle_count = 0;
   bit       calm        = 1'b0; // no idling on either side
   bit       hold_pending = 1'b0;

   rgb_to_hsv_converter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // exact integer hue, saturation and value of one pixel
   function automatic hsv_type hsv_of(input rgb_type px);
      int r, g, b, hi, lo, c, sect, d;
      hsv_type o;
      r  = px.red;
      g  = px.green;
      b  = px.blue;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      c = hi - lo;
      o = '0;
      if (c != 0) begin
         // sector pick: red wins ties, then green
         if (hi == r) begin
            d    = g - b;
            sect = (d < 0) ? 6 : 0;
         end else if (hi == g) begin
            d    = b - r;
            sect = 2;
         end else begin
            d    = r - g;
            sect = 4;
         end
         o.hue = chan_type'((255 * (sect * c + d)) / (6 * c));
      end
      if (hi != 0) o.saturation = chan_type'((c * 255) / hi);
      o.value = chan_type'(hi);
      return o;
   endfunction

   // random pixel, mostly uniform, with ties, greys, near-greys and 0 or 255 channels mixed in
   function automatic rgb_type random_pixel();
      rgb_type  px;
      chan_type base;
      px   = rgb_type'($urandom);
      base = chan_type'($urandom);
      case ($urandom_range(0, 9))
         0: px.green = px.red;                       // red ties green
         1: px.blue  = px.red;                       // red ties blue
         2: px.blue  = px.green;                     // green ties blue
         3: px = '{base, base, base};                // grey
         4: px = '{chan_type'(base ^ chan_type'($urandom_range(0, 3))), base,
                   chan_type'(base ^ chan_type'($urandom_range(0, 3)))};
         5: px.red   = chan_type'($urandom_range(0, 1) * 255);
         6: px.green = chan_type'($urandom_range(0, 1) * 255);
         7: px.blue  = chan_type'($urandom_range(0, 1) * 255);
         default: ;
      endcase
      return px;
   endfunction

   // offer one pixel and hold it until the transfer
   task automatic send_pixel(input rgb_type px, input hsv_type hsv);
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      offer_hsv  <= hsv;
      do @(posedge clock); while (!req_tready);
   endtask

   // random gap before the next pixel
   task automatic maybe_idle_req();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = LONG_HOLD - 1;
            rsp_tready   <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // record accepted pixels and check accepted results
   always @(posedge clock) begin
      hsv_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) hsv_due.push_back(offer_hsv);
         if (rsp_tvalid && rsp_tready) begin
            if (hsv_due.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("unexpected result: hue %0d sat %0d value %0d",
                           rsp_tdata.hue, rsp_tdata.saturation, rsp_tdata.value);
            end else begin
               want = hsv_due.pop_front();
               if (rsp_tdata !== want) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS)
                     $display("mismatch: hue %0d/%0d sat %0d/%0d value %0d/%0d (exp/got)",
                              want.hue, rsp_tdata.hue, want.saturation,
                              rsp_tdata.saturation, want.value, rsp_tdata.value);
               end
            end
         end
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      rgb_type px;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pixels
      for (int i = 0; i < NUM_CASES; i++) begin
         maybe_idle_req();
         px = PIXEL_CASES[i].pixel;
         send_pixel(px, PIXEL_CASES[i].known ? PIXEL_CASES[i].hsv : hsv_of(px));
      end

      // random pixels
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == HOLD_AT) hold_pending = 1'b1;
         if (i == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (hsv_due.size() != 0);
         end
         if (i == RANDOM_PIXELS - CALM_PIXELS) calm = 1'b1;
         maybe_idle_req();
         px = random_pixel();
         send_pixel(px, hsv_of(px));
      end
      req_tvalid <= 1'b0;

      // drain, then wait SETTLE_CYCLES for stray results
      while (hsv_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (hsv_due.size() != 0) fault_count++;

      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
